>>> sv/drs_pkg.sv
// Shared types and constants for the DTR/RTS auto-reset sequencer.
package drs_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PULSE     = 3'd1;
    localparam logic [2:0] PH_DL_PULSE  = 3'd2;
    localparam logic [2:0] PH_DL_SETTLE = 3'd3;
    localparam logic [2:0] PH_DL_HOLD   = 3'd4;

    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_RESET    = 2'd1;
    localparam logic [1:0] CMD_DOWNLOAD = 2'd2;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_RESET     = 2'd1;
    localparam logic [1:0] ST_DOWNLOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RST_DTR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd6;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd100;
    localparam logic [CFG_W-1:0] PULSE_RST    = 16'd100;
    localparam logic [CFG_W-1:0] SETTLE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd50;

    typedef struct packed {
        logic enable;
        logic invert;
        logic reset_on_dtr;
    } t_cfg_flags;

    typedef struct packed {
        logic       primed;
        logic       prev_request;
        logic [2:0] phase;
    } t_ctl;

    typedef struct packed {
        logic [1:0] started;
        logic       busy_res;
        logic       strap_drive;
        logic       reset_drive;
    } t_result;

endpackage

>>> sv/drs_step.sv
// Per-tick next-state and pin-drive logic of the sequencer.
module drs_step #(
    parameter int TIMER_BITS = drs_pkg::TIMER_BITS_DEF
) (
    input  logic                      i_dtr,
    input  logic                      i_rts,
    input  logic [1:0]                i_command,
    input  drs_pkg::t_cfg_flags       i_flags,
    input  logic [drs_pkg::CFG_W-1:0] i_debounce,
    input  logic [drs_pkg::CFG_W-1:0] i_pulse,
    input  logic [drs_pkg::CFG_W-1:0] i_settle,
    input  logic [drs_pkg::CFG_W-1:0] i_hold,
    input  drs_pkg::t_ctl             i_ctl,
    input  logic [TIMER_BITS-1:0]     i_since,
    input  logic [TIMER_BITS-1:0]     i_timer,
    output drs_pkg::t_ctl             o_ctl,
    output logic [TIMER_BITS-1:0]     o_since,
    output logic [TIMER_BITS-1:0]     o_timer,
    output drs_pkg::t_result          o_result
);

    localparam logic [32:0] TMAX_W = (33'd1 << TIMER_BITS) - 33'd1;
    localparam logic [TIMER_BITS-1:0] TMAX = TMAX_W[TIMER_BITS-1:0];

    function automatic logic [TIMER_BITS-1:0] clamp_t(input logic [drs_pkg::CFG_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > TMAX_W) ? TMAX : w[TIMER_BITS-1:0];
    endfunction

    logic                  dtr;
    logic                  rts;
    logic                  req;
    logic                  strap_req;
    logic                  edge_det;
    logic [TIMER_BITS-1:0] since_inc;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [TIMER_BITS-1:0] len;
    logic [TIMER_BITS-1:0] timer_mid;
    logic [2:0]            phase_mid;
    logic [2:0]            phase_nxt;
    logic [2:0]            next_of;
    logic [1:0]            started;

    always_comb begin
        dtr       = i_dtr ^ i_flags.invert;
        rts       = i_rts ^ i_flags.invert;
        req       = i_flags.reset_on_dtr ? dtr : rts;
        strap_req = i_flags.reset_on_dtr ? rts : dtr;
        edge_det  = i_ctl.primed && req && !i_ctl.prev_request;

        since_inc = (i_since < TMAX) ? i_since + 1'b1 : i_since;
        timer_inc = (i_timer < TMAX) ? i_timer + 1'b1 : i_timer;

        case (i_ctl.phase)
            drs_pkg::PH_PULSE: begin
                len     = clamp_t(i_pulse);
                next_of = drs_pkg::PH_IDLE;
            end
            drs_pkg::PH_DL_PULSE: begin
                len     = clamp_t(i_pulse);
                next_of = drs_pkg::PH_DL_SETTLE;
            end
            drs_pkg::PH_DL_SETTLE: begin
                len     = clamp_t(i_settle);
                next_of = drs_pkg::PH_DL_HOLD;
            end
            default: begin
                len     = clamp_t(i_hold);
                next_of = drs_pkg::PH_IDLE;
            end
        endcase

        phase_mid = i_ctl.phase;
        timer_mid = i_timer;
        if (i_ctl.phase != drs_pkg::PH_IDLE) begin
            if (timer_inc >= len) begin
                phase_mid = next_of;
                timer_mid = '0;
            end else begin
                timer_mid = timer_inc;
            end
        end

        phase_nxt = phase_mid;
        o_timer   = timer_mid;
        o_since   = since_inc;
        started   = drs_pkg::ST_NONE;
        if (phase_mid == drs_pkg::PH_IDLE) begin
            if (edge_det && i_flags.enable && since_inc >= clamp_t(i_debounce)) begin
                o_since   = '0;
                o_timer   = '0;
                phase_nxt = strap_req ? drs_pkg::PH_DL_PULSE : drs_pkg::PH_PULSE;
                started   = strap_req ? drs_pkg::ST_DOWNLOAD : drs_pkg::ST_RESET;
            end else if (i_command == drs_pkg::CMD_RESET) begin
                o_timer   = '0;
                phase_nxt = drs_pkg::PH_PULSE;
                started   = drs_pkg::ST_RESET;
            end else if (i_command == drs_pkg::CMD_DOWNLOAD) begin
                o_timer   = '0;
                phase_nxt = drs_pkg::PH_DL_PULSE;
                started   = drs_pkg::ST_DOWNLOAD;
            end
        end

        o_ctl.primed       = 1'b1;
        o_ctl.prev_request = req;
        o_ctl.phase        = phase_nxt;

        o_result.reset_drive = (phase_nxt == drs_pkg::PH_PULSE)
                            || (phase_nxt == drs_pkg::PH_DL_PULSE)
                            || (phase_nxt == drs_pkg::PH_DL_SETTLE);
        o_result.strap_drive = (phase_nxt == drs_pkg::PH_DL_SETTLE)
                            || (phase_nxt == drs_pkg::PH_DL_HOLD);
        o_result.busy_res    = (phase_nxt != drs_pkg::PH_IDLE);
        o_result.started     = started;
    end

endmodule

>>> sv/dtr_rts_auto_reset_sequencer_core.sv
// Top level of the DTR/RTS auto-reset sequencer: config, state and output register.
// The result of an accepted tick request is registered in the output register.
// Throughput: one tick request per cycle unless the output is stalled; the output register lets a new request in
// while the previous result is taken in the same cycle.
// Reset (synchronous, active low): config returns to defaults, the sequencer goes idle
// and unprimed, both timers clear and the output register empties.
module dtr_rts_auto_reset_sequencer_core #(
    parameter int TIMER_BITS = drs_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // dtr_line, rts_line, command[1:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // reset_drive, strap_drive,
                                                           // busy_res, started[1:0]
    input  logic                          i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drs_pkg::CFG_W-1:0]     i_cfg_data
);

    drs_pkg::t_cfg_flags       r_flags;
    logic [drs_pkg::CFG_W-1:0] r_debounce;
    logic [drs_pkg::CFG_W-1:0] r_pulse;
    logic [drs_pkg::CFG_W-1:0] r_settle;
    logic [drs_pkg::CFG_W-1:0] r_hold;

    drs_pkg::t_ctl             r_ctl;
    logic [TIMER_BITS-1:0]     r_since;
    logic [TIMER_BITS-1:0]     r_timer;
    logic                      r_out_valid;
    drs_pkg::t_result          r_out;

    drs_pkg::t_ctl             n_ctl;
    logic [TIMER_BITS-1:0]     n_since;
    logic [TIMER_BITS-1:0]     n_timer;
    drs_pkg::t_result          n_out;
    logic                      in_acc;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

    drs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_dtr      (i_s_axis_tdata[0]),
        .i_rts      (i_s_axis_tdata[1]),
        .i_command  (i_s_axis_tdata[3:2]),
        .i_flags    (r_flags),
        .i_debounce (r_debounce),
        .i_pulse    (r_pulse),
        .i_settle   (r_settle),
        .i_hold     (r_hold),
        .i_ctl      (r_ctl),
        .i_since    (r_since),
        .i_timer    (r_timer),
        .o_ctl      (n_ctl),
        .o_since    (n_since),
        .o_timer    (n_timer),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.enable       <= 1'b1;
            r_flags.invert       <= 1'b0;
            r_flags.reset_on_dtr <= 1'b1;
            r_debounce           <= drs_pkg::DEBOUNCE_RST;
            r_pulse              <= drs_pkg::PULSE_RST;
            r_settle             <= drs_pkg::SETTLE_RST;
            r_hold               <= drs_pkg::HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drs_pkg::REG_ENABLE:   r_flags.enable       <= i_cfg_data[0];
                drs_pkg::REG_INVERT:   r_flags.invert       <= i_cfg_data[0];
                drs_pkg::REG_RST_DTR:  r_flags.reset_on_dtr <= i_cfg_data[0];
                drs_pkg::REG_DEBOUNCE: r_debounce           <= i_cfg_data;
                drs_pkg::REG_PULSE:    r_pulse              <= i_cfg_data;
                drs_pkg::REG_SETTLE:   r_settle             <= i_cfg_data;
                drs_pkg::REG_HOLD:     r_hold               <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.primed       <= 1'b0;
            r_ctl.prev_request <= 1'b0;
            r_ctl.phase        <= drs_pkg::PH_IDLE;
            r_since            <= '0;
            r_timer            <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ctl   <= n_ctl;
                r_since <= n_since;
                r_timer <= n_timer;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase <= drs_pkg::PH_DL_HOLD)
        else $error("phase code out of range");

    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out.busy_res == (r_ctl.phase != drs_pkg::PH_IDLE)))
        else $error("busy result does not match phase");

    a_start_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.started != drs_pkg::ST_NONE) |->
        (r_out.busy_res && r_out.reset_drive && !r_out.strap_drive))
        else $error("started without reset pulse");

    a_primed_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_ctl.primed)
        else $error("edge detector not primed after a tick");
`endif

endmodule

>>> tb/sv/drs_tick_checker.sv
// Checker for the auto-reset sequencer: tracks config, predicts pin drives and compares results.
module drs_tick_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    input  logic                          i_s_ready,
    input  logic [7:0]                    i_s_data,   // dtr_line, rts_line, command[1:0]
    input  logic                          i_m_valid,
    input  logic                          i_m_ready,
    input  logic [7:0]                    i_m_data,   // reset_drive, strap_drive, busy_res,
                                                      // started[1:0]
    input  logic                          i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drs_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    drs_pkg::t_cfg_flags       flags;
    logic [drs_pkg::CFG_W-1:0] debounce_len;
    logic [drs_pkg::CFG_W-1:0] pulse_len;
    logic [drs_pkg::CFG_W-1:0] settle_len;
    logic [drs_pkg::CFG_W-1:0] hold_len;

    logic             primed;
    logic             prev_req;
    logic [15:0]      since_accept;
    logic [15:0]      phase_timer;
    logic [2:0]       phase;

    drs_pkg::t_result drive_q[$];
    int               fails = 0;

    function automatic logic [15:0] phase_ticks(input logic [2:0] ph);
        if (ph == drs_pkg::PH_PULSE || ph == drs_pkg::PH_DL_PULSE)
            return pulse_len;
        if (ph == drs_pkg::PH_DL_SETTLE)
            return settle_len;
        return hold_len;
    endfunction

    task automatic note_fail(input string msg);
        if (fails < 10)
            $display("mismatch: %s", msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            note_fail($sformatf("%s expected %0d actual %0d", name, want, got));
    endtask

    // One tick of the sequencer; updates the tracked state.
    task automatic advance_sequencer(input logic [7:0] d, output drs_pkg::t_result r);
        logic       dtr;
        logic       rts;
        logic       req;
        logic       strap;
        logic       rise;
        logic [1:0] cmd;
        dtr   = d[0] ^ flags.invert;
        rts   = d[1] ^ flags.invert;
        cmd   = d[3:2];
        req   = flags.reset_on_dtr ? dtr : rts;
        strap = flags.reset_on_dtr ? rts : dtr;
        rise  = 1'b0;
        r     = '0;

        if (since_accept != 16'hFFFF)
            since_accept++;

        if (phase != drs_pkg::PH_IDLE) begin
            if (phase_timer != 16'hFFFF)
                phase_timer++;
            if (phase_timer >= phase_ticks(phase)) begin
                case (phase)
                    drs_pkg::PH_DL_PULSE:  phase = drs_pkg::PH_DL_SETTLE;
                    drs_pkg::PH_DL_SETTLE: phase = drs_pkg::PH_DL_HOLD;
                    default:               phase = drs_pkg::PH_IDLE;
                endcase
                phase_timer = '0;
            end
        end

        if (!primed)
            primed = 1'b1;
        else
            rise = req && !prev_req;
        prev_req = req;

        if (phase == drs_pkg::PH_IDLE) begin
            if (rise && flags.enable && since_accept >= debounce_len) begin
                since_accept = '0;
                phase        = strap ? drs_pkg::PH_DL_PULSE : drs_pkg::PH_PULSE;
                phase_timer  = '0;
                r.started    = strap ? drs_pkg::ST_DOWNLOAD : drs_pkg::ST_RESET;
            end else if (cmd == drs_pkg::CMD_RESET || cmd == drs_pkg::CMD_DOWNLOAD) begin
                phase       = (cmd == drs_pkg::CMD_DOWNLOAD) ? drs_pkg::PH_DL_PULSE
                                                             : drs_pkg::PH_PULSE;
                phase_timer = '0;
                r.started   = (cmd == drs_pkg::CMD_DOWNLOAD) ? drs_pkg::ST_DOWNLOAD
                                                             : drs_pkg::ST_RESET;
            end
        end

        r.reset_drive = (phase == drs_pkg::PH_PULSE || phase == drs_pkg::PH_DL_PULSE
                         || phase == drs_pkg::PH_DL_SETTLE);
        r.strap_drive = (phase == drs_pkg::PH_DL_SETTLE || phase == drs_pkg::PH_DL_HOLD);
        r.busy_res    = (phase != drs_pkg::PH_IDLE);
    endtask

    always @(posedge i_clk) begin
        drs_pkg::t_result got;
        drs_pkg::t_result want;
        drs_pkg::t_result pred;
        if (!i_rst_n) begin
            flags.enable       = 1'b1;
            flags.invert       = 1'b0;
            flags.reset_on_dtr = 1'b1;
            debounce_len       = drs_pkg::DEBOUNCE_RST;
            pulse_len          = drs_pkg::PULSE_RST;
            settle_len         = drs_pkg::SETTLE_RST;
            hold_len           = drs_pkg::HOLD_RST;
            primed             = 1'b0;
            prev_req           = 1'b0;
            since_accept       = '0;
            phase_timer        = '0;
            phase              = drs_pkg::PH_IDLE;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    drs_pkg::REG_ENABLE:   flags.enable       = i_cfg_data[0];
                    drs_pkg::REG_INVERT:   flags.invert       = i_cfg_data[0];
                    drs_pkg::REG_RST_DTR:  flags.reset_on_dtr = i_cfg_data[0];
                    drs_pkg::REG_DEBOUNCE: debounce_len       = i_cfg_data;
                    drs_pkg::REG_PULSE:    pulse_len          = i_cfg_data;
                    drs_pkg::REG_SETTLE:   settle_len         = i_cfg_data;
                    drs_pkg::REG_HOLD:     hold_len           = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before queuing so a same-edge request cannot match itself
            if (i_m_valid && i_m_ready) begin
                got = drs_pkg::t_result'(i_m_data[4:0]);
                if (drive_q.size() == 0) begin
                    note_fail($sformatf("result %h with no request pending", i_m_data));
                end else begin
                    want = drive_q.pop_front();
                    check_field("reset_drive", want.reset_drive, got.reset_drive);
                    check_field("strap_drive", want.strap_drive, got.strap_drive);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("started", want.started, got.started);
                end
            end
            if (i_s_valid && i_s_ready) begin
                advance_sequencer(i_s_data, pred);
                drive_q.push_back(pred);
            end
        end
        o_pending    <= drive_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/sv/tb_dtr_rts_auto_reset_sequencer_core.sv
// Testbench top for the auto-reset sequencer: clock, reset, stimulus, config phases and verdict.
module tb_dtr_rts_auto_reset_sequencer_core;

    localparam int                            STALL_LIMIT = 2000;
    localparam logic [drs_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [1:0]                    CMD_SPARE   = 2'd3;

    logic                          clk     = 1'b0;
    logic                          rst_n   = 1'b0;
    logic                          s_valid = 1'b0;
    logic [7:0]                    s_data  = '0;
    logic                          m_ready = 1'b0;
    logic                          cfg_we  = 1'b0;
    logic [drs_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [drs_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          calm    = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic [7:0]                    m_data;
    int                            fail_count;
    int                            pending;
    int                            quiet_cycles = 0;
    logic                          dtr_lvl = 1'b0;
    logic                          rts_lvl = 1'b0;

    always #1 clk = ~clk;

    dtr_rts_auto_reset_sequencer_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    drs_tick_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(input logic dtr, input logic rts, input logic [1:0] cmd);
        while (!calm && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0000, cmd, rts, dtr};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Flag registers get random upper bits; the unused index is written too.
    task automatic write_regs(input logic en, input logic inv, input logic rst_dtr,
                              input logic [drs_pkg::CFG_W-1:0] deb,
                              input logic [drs_pkg::CFG_W-1:0] pul,
                              input logic [drs_pkg::CFG_W-1:0] set,
                              input logic [drs_pkg::CFG_W-1:0] hld);
        logic [drs_pkg::CFG_W-1:0] vals[8];
        vals[drs_pkg::REG_ENABLE]   = {15'($urandom), en};
        vals[drs_pkg::REG_INVERT]   = {15'($urandom), inv};
        vals[drs_pkg::REG_RST_DTR]  = {15'($urandom), rst_dtr};
        vals[drs_pkg::REG_DEBOUNCE] = deb;
        vals[drs_pkg::REG_PULSE]    = pul;
        vals[drs_pkg::REG_SETTLE]   = set;
        vals[drs_pkg::REG_HOLD]     = hld;
        vals[REG_UNUSED]            = 16'($urandom);
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[drs_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly line toggles with occasional commands; some fully random noise.
    task automatic random_ticks(input int n);
        int         roll;
        logic [1:0] cmd;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                dtr_lvl = 1'($urandom_range(0, 1));
                rts_lvl = 1'($urandom_range(0, 1));
                cmd     = 2'($urandom_range(0, 3));
            end else begin
                if ($urandom_range(0, 3) == 0)
                    dtr_lvl = ~dtr_lvl;
                if ($urandom_range(0, 3) == 0)
                    rts_lvl = ~rts_lvl;
                roll = $urandom_range(0, 99);
                cmd  = (roll < 6)  ? drs_pkg::CMD_RESET :
                       (roll < 12) ? drs_pkg::CMD_DOWNLOAD :
                       (roll < 15) ? CMD_SPARE : drs_pkg::CMD_NONE;
            end
            send_tick(dtr_lvl, rts_lvl, cmd);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: priming tick, debounced edge, spare command, command ignored while busy
        send_tick(1'b1, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b1, 1'b1, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, CMD_SPARE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_RESET);
        send_tick(1'b1, 1'b0, drs_pkg::CMD_DOWNLOAD);
        drain();

        // zero-length phases, edge beating a command, back-to-back start
        write_regs(1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd1);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_DOWNLOAD);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b1, 1'b1, drs_pkg::CMD_RESET);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b1, 1'b0, drs_pkg::CMD_NONE);
        drain();

        // lines disabled, inverted and swapped; commands still act
        write_regs(1'b0, 1'b1, 1'b0, 16'd2, 16'd1, 16'd0, 16'd0);
        send_tick(1'b1, 1'b1, drs_pkg::CMD_NONE);
        send_tick(1'b1, 1'b0, drs_pkg::CMD_NONE);
        send_tick(1'b1, 1'b0, drs_pkg::CMD_RESET);
        send_tick(1'b1, 1'b1, drs_pkg::CMD_NONE);
        send_tick(1'b0, 1'b0, drs_pkg::CMD_DOWNLOAD);
        send_tick(1'b0, 1'b1, drs_pkg::CMD_NONE);
        drain();

        write_regs(1'b1, 1'b0, 1'b1, drs_pkg::DEBOUNCE_RST, drs_pkg::PULSE_RST,
                   drs_pkg::SETTLE_RST, drs_pkg::HOLD_RST);
        random_ticks(150);
        drain();

        calm <= 1'b1;
        write_regs(1'b1, 1'b0, 1'b1, 16'd3, 16'd2, 16'd1, 16'd3);
        random_ticks(150);
        drain();
        calm <= 1'b0;

        write_regs(1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_ticks(150);
        drain();

        write_regs(1'b0, 1'b1, 1'b1, 16'd5, 16'd4, 16'd2, 16'd1);
        random_ticks(100);
        drain();

        write_regs(1'b1, 1'b0, 1'b0, 16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
        random_ticks(150);
        drain();

        write_regs(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_ticks(60);
        drain();

        write_regs(1'b1, 1'b0, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
        random_ticks(150);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
sv/drs_pkg.sv
sv/drs_step.sv
sv/dtr_rts_auto_reset_sequencer_core.sv
tb/sv/drs_tick_checker.sv
tb/sv/tb_dtr_rts_auto_reset_sequencer_core.sv
